/* sv/sh4_group6_move_logic_unit_assert.svh */
// assertion macros for the group-6 move/logic unit
`ifndef SH4_GROUP6_MOVE_LOGIC_UNIT_ASSERT_SVH
`define SH4_GROUP6_MOVE_LOGIC_UNIT_ASSERT_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define SH4G6_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sh4g6 assertion failed");
// condition implies a consequence in the next cycle
`define SH4G6_ASSERT_NEXT(lbl, pre, post) \
  `SH4G6_ASSERT(lbl, (pre) |=> (post))
`else
`define SH4G6_ASSERT(lbl, prop)
`define SH4G6_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* sv/sh4g6_pkg.sv */
// types and constants shared by the group-6 move/logic unit
`default_nettype none

package sh4g6_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned REG_N  = 16;
  localparam int unsigned REG_AW = 4;
  localparam int unsigned INS_W  = 16;
  localparam int unsigned SIZE_W = 3;

  // kinds of request on the input channel
  typedef enum logic [1:0] {
    ACT_EXEC   = 2'd0,
    ACT_RETURN = 2'd1,
    ACT_WREG   = 2'd2,
    ACT_WT     = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_READ    = 2'd1,
    ST_BADOP   = 2'd2,
    ST_ORDER   = 2'd3
  } status_e;

  // group nibble and low-nibble opcodes
  localparam logic [3:0] GROUP_NIBBLE = 4'h6;
  localparam logic [3:0] OP_MOV   = 4'd3;
  localparam logic [3:0] OP_NOT   = 4'd7;
  localparam logic [3:0] OP_SWAPB = 4'd8;
  localparam logic [3:0] OP_SWAPW = 4'd9;
  localparam logic [3:0] OP_NEGC  = 4'd10;
  localparam logic [3:0] OP_NEG   = 4'd11;
  localparam logic [3:0] OP_EXTUB = 4'd12;
  localparam logic [3:0] OP_EXTUW = 4'd13;
  localparam logic [3:0] OP_EXTSB = 4'd14;

  // access sizes in bytes
  localparam logic [SIZE_W-1:0] SZ_NONE = 3'd0;
  localparam logic [SIZE_W-1:0] SZ_BYTE = 3'd1;
  localparam logic [SIZE_W-1:0] SZ_WORD = 3'd2;
  localparam logic [SIZE_W-1:0] SZ_LONG = 3'd4;

  // request held in the execute stage
  typedef struct packed {
    logic                valid;
    action_e             action;
    status_e             status;
    logic [INS_W-1:0]    instruction;
    logic [DATA_W-1:0]   data_word;
    logic [REG_AW-1:0]   target;
    logic [REG_AW-1:0]   rd_addr;
    logic [REG_AW-1:0]   pend_dest;
    logic [REG_AW-1:0]   pend_base;
    logic [SIZE_W-1:0]   pend_size;
    logic                pend_postinc;
  } stage_t;

  // result payload
  typedef struct packed {
    status_e             status;
    logic [REG_AW-1:0]   wreg;
    logic [DATA_W-1:0]   wval;
    logic                t_flag;
    logic [DATA_W-1:0]   raddr;
    logic [SIZE_W-1:0]   rsize;
    logic                adv;
  } result_t;

  // register-file write-back requests
  typedef struct packed {
    logic                we;
    logic [REG_AW-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;
    logic                inc;
    logic [REG_AW-1:0]   inc_addr;
    logic [DATA_W-1:0]   inc_data;
  } wback_t;

  function automatic logic [DATA_W-1:0] sext8(input logic [DATA_W-1:0] v);
    return {{(DATA_W-8){v[7]}}, v[7:0]};
  endfunction

  function automatic logic [DATA_W-1:0] sext16(input logic [DATA_W-1:0] v);
    return {{(DATA_W-16){v[15]}}, v[15:0]};
  endfunction

endpackage

`default_nettype wire

/* sv/sh4g6_if.sv */
// request and result channel interfaces
`default_nettype none

interface sh4g6_in_if;
  import sh4g6_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [INS_W-1:0]    instruction;
  logic [DATA_W-1:0]   data_word;
  logic [REG_AW-1:0]   target_register;

  modport source (output valid, action, instruction, data_word, target_register,
                  input ready);
  modport sink   (input valid, action, instruction, data_word, target_register,
                  output ready);
endinterface

interface sh4g6_out_if;
  import sh4g6_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [REG_AW-1:0]   written_register;
  logic [DATA_W-1:0]   written_value;
  logic                t_flag_out;
  logic [DATA_W-1:0]   read_address;
  logic [SIZE_W-1:0]   read_size;
  logic                advance_pc;

  modport source (output valid, status, written_register, written_value, t_flag_out,
                  read_address, read_size, advance_pc, input ready);
  modport sink   (input valid, status, written_register, written_value, t_flag_out,
                  read_address, read_size, advance_pc, output ready);
endinterface

`default_nettype wire

/* sv/sh4_group6_move_logic_unit.sv */
// top level of the group-6 move/logic unit
//
// Executes 0110nnnnmmmmxxxx instructions against a 16 x 32 register file kept
// in a synchronous ram, plus the T flag. Input channel in_i carries one request:
// execute, load data return, register write or T write. Output channel out_o
// returns exactly one result per request, in order.
// A request is accepted into the execute stage with its ram read at the accepting
// edge, then executed into the output register that drives out_o.
// Throughput: one request per cycle while out_o is ready. After the data return
// of an @Rm+ load with Rm different from Rn the execute stage holds, since the
// base increment takes the single ram write port the cycle after the Rn write.
// Read-after-write between neighboring requests is covered by a one-entry
// forward register on the ram write port.
// Reset: all registers read as zero through per-entry valid bits, T and the
// pending load are cleared at once; no clearing pass is needed.
// Stall: when out_o is not ready the output register holds its result, the
// execute stage holds and re-reads its register, and in_i.ready drops.
`default_nettype none
`include "sh4_group6_move_logic_unit_assert.svh"

module sh4_group6_move_logic_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sh4g6_in_if.sink   in_i,
  sh4g6_out_if.source out_o
);
  import sh4g6_pkg::*;

  stage_t              s1;
  logic                s1_adv;
  logic [REG_AW-1:0]   rd_addr;
  logic [DATA_W-1:0]   ram_rdata;
  logic                ram_we;
  logic [REG_AW-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   a_val;
  result_t             res;
  wback_t              wb;

  logic [REG_N-1:0]    rf_valid_q;
  logic                fwd_valid_q;
  logic [REG_AW-1:0]   fwd_addr_q;
  logic [DATA_W-1:0]   fwd_data_q;
  logic                t_q;
  logic                inc_q;
  logic [REG_AW-1:0]   inc_addr_q;
  logic [DATA_W-1:0]   inc_data_q;
  logic                out_valid_q;
  result_t             out_q;

  // execute stage moves when the base increment is done and output has room
  assign s1_adv = s1.valid && !inc_q && (!out_valid_q || out_o.ready);

  sh4g6_issue u_issue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .s1_adv_i (s1_adv),
    .s1_o     (s1),
    .rd_addr_o(rd_addr)
  );

  // ram write port: stage write or the deferred base increment
  assign ram_we    = (s1_adv && wb.we) || inc_q;
  assign ram_waddr = inc_q ? inc_addr_q : wb.waddr;
  assign ram_wdata = inc_q ? inc_data_q : wb.wdata;

  sh4g6_ram #(
    .WIDTH(DATA_W),
    .DEPTH(REG_N)
  ) u_rf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // operand: last write forwarded, never-written entries read as zero
  always_comb begin
    if (fwd_valid_q && fwd_addr_q == s1.rd_addr) begin
      a_val = fwd_data_q;
    end else if (rf_valid_q[s1.rd_addr]) begin
      a_val = ram_rdata;
    end else begin
      a_val = '0;
    end
  end

  sh4g6_alu u_alu (
    .s1_i (s1),
    .a_i  (a_val),
    .t_i  (t_q),
    .res_o(res),
    .wb_o (wb)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q  <= '0;
      fwd_valid_q <= 1'b0;
      t_q         <= 1'b0;
      inc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= ram_we;
      if (ram_we) begin
        rf_valid_q[ram_waddr] <= 1'b1;
      end
      if (s1_adv) begin
        t_q <= res.t_flag;
      end
      inc_q <= s1_adv && wb.inc;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fwd_addr_q <= ram_waddr;
    fwd_data_q <= ram_wdata;
    if (s1_adv) begin
      inc_addr_q <= wb.inc_addr;
      inc_data_q <= wb.inc_data;
      out_q      <= res;
    end
  end

  // result channel
  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_q.status;
  assign out_o.written_register = out_q.wreg;
  assign out_o.written_value    = out_q.wval;
  assign out_o.t_flag_out       = out_q.t_flag;
  assign out_o.read_address     = out_q.raddr;
  assign out_o.read_size        = out_q.rsize;
  assign out_o.advance_pc       = out_q.adv;

  // checks
  `SH4G6_ASSERT(a_inc_after_return, inc_q |-> $past(s1_adv && s1.action == ACT_RETURN))
  `SH4G6_ASSERT_NEXT(a_stall_holds, s1.valid && !s1_adv, s1.valid && $stable(s1.rd_addr))
  `SH4G6_ASSERT_NEXT(a_write_marks_valid, ram_we, rf_valid_q[$past(ram_waddr)])

endmodule

`default_nettype wire

/* sv/sh4g6_ram.sv */
// generic single-write, single-read ram with registered read
`default_nettype none

module sh4g6_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/sh4g6_issue.sv */
// accept stage: load-pending tracking, status decision, register read issue
`default_nettype none

module sh4g6_issue (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  sh4g6_in_if.sink                      in_i,
  input  wire logic                     s1_adv_i,
  output      sh4g6_pkg::stage_t        s1_o,
  output      logic [sh4g6_pkg::REG_AW-1:0] rd_addr_o
);
  import sh4g6_pkg::*;

  logic                pend_q;
  logic [REG_AW-1:0]   pend_dest_q;
  logic [REG_AW-1:0]   pend_base_q;
  logic [SIZE_W-1:0]   pend_size_q;
  logic                pend_postinc_q;
  logic                s1_valid_q;
  stage_t              s1_q;
  stage_t              s1_d;

  action_e             act;
  logic                take;
  logic                accept;
  logic [3:0]          op;
  logic                in_group;
  logic                is_load;
  logic [SIZE_W-1:0]   ld_size;
  status_e             status;
  logic [REG_AW-1:0]   new_addr;

  // decode of the incoming request
  always_comb begin
    act      = action_e'(in_i.action);
    op       = in_i.instruction[3:0];
    in_group = (in_i.instruction[15:12] == GROUP_NIBBLE);
    is_load  = op inside {[4'd0:4'd2], [4'd4:4'd6]};
    case (op[1:0])
      2'd0:    ld_size = SZ_BYTE;
      2'd1:    ld_size = SZ_WORD;
      default: ld_size = SZ_LONG;
    endcase
  end

  // status known at accept time
  always_comb begin
    case (act)
      ACT_EXEC: begin
        if (pend_q) begin
          status = ST_ORDER;
        end else if (!in_group) begin
          status = ST_BADOP;
        end else if (is_load) begin
          status = ST_READ;
        end else begin
          status = ST_WRITTEN;
        end
      end
      ACT_RETURN: status = pend_q ? ST_WRITTEN : ST_ORDER;
      default:    status = ST_WRITTEN;
    endcase
  end

  // handshake and read address: re-read the held address while stalled
  assign take      = !s1_valid_q || s1_adv_i;
  assign in_i.ready = take;
  assign accept    = in_i.valid && take;
  assign new_addr  = (act == ACT_RETURN) ? pend_base_q : in_i.instruction[7:4];
  assign rd_addr_o = take ? new_addr : s1_q.rd_addr;

  // next execute-stage payload
  always_comb begin
    s1_d              = s1_q;
    s1_d.valid        = 1'b1;
    s1_d.action       = act;
    s1_d.status       = status;
    s1_d.instruction  = in_i.instruction;
    s1_d.data_word    = in_i.data_word;
    s1_d.target       = in_i.target_register;
    s1_d.rd_addr      = new_addr;
    s1_d.pend_dest    = pend_dest_q;
    s1_d.pend_base    = pend_base_q;
    s1_d.pend_size    = pend_size_q;
    s1_d.pend_postinc = pend_postinc_q;
  end

  // pending load state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q         <= 1'b0;
      pend_dest_q    <= '0;
      pend_base_q    <= '0;
      pend_size_q    <= SZ_NONE;
      pend_postinc_q <= 1'b0;
      s1_valid_q     <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_q <= in_i.valid;
      end
      if (accept && act == ACT_EXEC && status == ST_READ) begin
        pend_q         <= 1'b1;
        pend_dest_q    <= in_i.instruction[11:8];
        pend_base_q    <= in_i.instruction[7:4];
        pend_size_q    <= ld_size;
        pend_postinc_q <= op[2];
      end else if (accept && act == ACT_RETURN) begin
        pend_q <= 1'b0;
      end
    end
  end

  // stage payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    s1_o       = s1_q;
    s1_o.valid = s1_valid_q;
  end

endmodule

`default_nettype wire

/* sv/sh4g6_alu.sv */
// execute stage: register operations, load extension and write-back requests
`default_nettype none

module sh4g6_alu (
  input  wire sh4g6_pkg::stage_t            s1_i,
  input  wire logic [sh4g6_pkg::DATA_W-1:0] a_i,
  input  wire logic                         t_i,
  output      sh4g6_pkg::result_t           res_o,
  output      sh4g6_pkg::wback_t            wb_o
);
  import sh4g6_pkg::*;

  logic [3:0]        op;
  logic [REG_AW-1:0] rn;
  logic [DATA_W-1:0] r;
  logic [DATA_W-1:0] neg_a;
  logic [DATA_W-1:0] ld_val;

  assign op    = s1_i.instruction[3:0];
  assign rn    = s1_i.instruction[11:8];
  assign neg_a = '0 - a_i;

  // register-form result
  always_comb begin
    case (op)
      OP_MOV:   r = a_i;
      OP_NOT:   r = ~a_i;
      OP_SWAPB: r = {a_i[31:16], a_i[7:0], a_i[15:8]};
      OP_SWAPW: r = {a_i[15:0], a_i[31:16]};
      OP_NEGC:  r = neg_a - {{(DATA_W-1){1'b0}}, t_i};
      OP_NEG:   r = neg_a;
      OP_EXTUB: r = {{(DATA_W-8){1'b0}}, a_i[7:0]};
      OP_EXTUW: r = {{(DATA_W-16){1'b0}}, a_i[15:0]};
      OP_EXTSB: r = sext8(a_i);
      default:  r = sext16(a_i);
    endcase
  end

  // extend returned load data
  always_comb begin
    if (s1_i.pend_size == SZ_BYTE) begin
      ld_val = sext8(s1_i.data_word);
    end else if (s1_i.pend_size == SZ_WORD) begin
      ld_val = sext16(s1_i.data_word);
    end else begin
      ld_val = s1_i.data_word;
    end
  end

  // result and write-back per request kind
  always_comb begin
    res_o        = '0;
    res_o.status = s1_i.status;
    res_o.t_flag = t_i;
    res_o.rsize  = SZ_NONE;
    wb_o         = '0;
    case (s1_i.action)
      ACT_EXEC: begin
        if (s1_i.status == ST_READ) begin
          res_o.raddr = a_i;
          res_o.rsize = (op[1:0] == 2'd0) ? SZ_BYTE :
                        (op[1:0] == 2'd1) ? SZ_WORD : SZ_LONG;
        end else if (s1_i.status == ST_WRITTEN) begin
          res_o.wreg = rn;
          res_o.wval = r;
          res_o.adv  = 1'b1;
          wb_o.we    = 1'b1;
          wb_o.waddr = rn;
          wb_o.wdata = r;
          // borrow out of 0 - Rm - T
          if (op == OP_NEGC) begin
            res_o.t_flag = (a_i != '0) || t_i;
          end
        end
      end
      ACT_RETURN: begin
        if (s1_i.status == ST_WRITTEN) begin
          res_o.wreg    = s1_i.pend_dest;
          res_o.wval    = ld_val;
          res_o.adv     = 1'b1;
          wb_o.we       = 1'b1;
          wb_o.waddr    = s1_i.pend_dest;
          wb_o.wdata    = ld_val;
          // post-increment of the base, a_i holds Rm read at return
          wb_o.inc      = s1_i.pend_postinc && (s1_i.pend_base != s1_i.pend_dest);
          wb_o.inc_addr = s1_i.pend_base;
          wb_o.inc_data = a_i + {{(DATA_W-SIZE_W){1'b0}}, s1_i.pend_size};
        end
      end
      ACT_WREG: begin
        res_o.wreg = s1_i.target;
        res_o.wval = s1_i.data_word;
        wb_o.we    = 1'b1;
        wb_o.waddr = s1_i.target;
        wb_o.wdata = s1_i.data_word;
      end
      default: begin
        res_o.t_flag = s1_i.data_word[0];
        res_o.wval   = {{(DATA_W-1){1'b0}}, s1_i.data_word[0]};
      end
    endcase
  end

endmodule

`default_nettype wire
